FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file mtte_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ANY(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/core/mtte_pkg.sv
package mtte_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [2:0] REQ_REG    = 3'd0;
  localparam logic [2:0] REQ_ARM    = 3'd1;
  localparam logic [2:0] REQ_ADV    = 3'd2;
  localparam logic [2:0] REQ_FETCH  = 3'd3;
  localparam logic [2:0] REQ_LOOKUP = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXISTS  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] remaining;
    logic [31:0] period;
    logic [63:0] expected;
    logic        tick_set;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic scan_end;
    logic chk;
    logic rld;
    logic div_start;
    logic div_fin;
    logic rwr;
    logic shr;
    logic shw;
    logic sh_end;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_more;
    logic hit;
    logic is_fetch;
    logic periodic;
    logic need_div;
    logic sh_more;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/core/mtte_mod.sv
module mtte_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [31:0] part;
  logic [31:0] dsr;
  logic [32:0] trial;

  // Restoring remainder, one dividend bit per cycle.
  assign trial = {part, dvd[63]};
  assign remainder = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      part <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        part <= 32'(trial - {1'b0, dsr});
      end else begin
        part <= trial[31:0];
      end
    end
  end

endmodule

FILE: rtl/core/mtte_dp.sv
module mtte_dp import mtte_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [2:0]    req_type,
  input  logic [31:0]   timer_id,
  input  logic [31:0]   wait_ms,
  input  logic [31:0]   period_ms,
  input  logic [63:0]   now_tick,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic [2:0]    status,
  output logic [31:0]   fired_id,
  output logic [31:0]   remaining_ms,
  output logic [31:0]   entry_period,
  output logic [CW-1:0] live_count
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  entry_t mem [SLOTS];
  entry_t rdata;
  entry_t wdata;
  logic            we;
  logic            re;
  logic [IW-1:0]   waddr;
  logic [IW-1:0]   raddr;

  logic [2:0]    req;
  logic [31:0]   rid;
  logic [31:0]   rwait;
  logic [31:0]   rper;
  logic [63:0]   rnow;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] count;
  logic [CW-1:0] cursor;
  logic [63:0]   arm_start;
  logic [31:0]   min_val;
  logic [63:0]   diff;
  logic [31:0]   r_val;
  logic [2:0]    res_st;
  logic [31:0]   res_fid;
  logic [31:0]   res_rem;
  logic [31:0]   res_per;

  logic          req_known;
  logic          full;
  logic [31:0]   adv_rem;
  logic [31:0]   early;
  logic [32:0]   late_sum;
  logic [31:0]   rld_val;
  logic          div_done;
  logic [31:0]   div_rem;

  assign idx_p1    = idx + CW'(1);
  assign req_known = (req <= REQ_LOOKUP);
  assign full      = (count == CW'(SLOTS));
  assign adv_rem   = ({32'd0, rdata.remaining} <= diff) ? 32'd0 :
                     32'(rdata.remaining - diff[31:0]);

  // Reload for a periodic timer that has never fired, is early, or is less than a period late.
  assign early    = 32'(~diff[31:0] + 32'd1);
  assign late_sum = {1'b0, rdata.period} + {1'b0, early};
  always_comb begin
    if (!rdata.tick_set) begin
      rld_val = rdata.period;
    end else if (diff[63]) begin
      if ((diff[63:32] == '1) && (diff[31:0] != '0) && !late_sum[32]) begin
        rld_val = late_sum[31:0];
      end else begin
        rld_val = '1;
      end
    end else begin
      rld_val = 32'(rdata.period - diff[31:0]);
    end
  end

  always_comb begin
    sts           = '0;
    sts.scan_more = req_known && (idx < count);
    sts.is_fetch  = (req == REQ_FETCH);
    sts.periodic  = (rdata.period != '0);
    sts.need_div  = rdata.tick_set && !diff[63] &&
                    ((diff[63:32] != '0) || (diff[31:0] >= rdata.period));
    sts.sh_more   = (idx_p1 < count);
    sts.div_done  = div_done;
    sts.out_busy  = rsp_valid && rsp_stall;
    case (req)
      REQ_REG, REQ_LOOKUP: sts.hit = (rdata.id == rid);
      REQ_FETCH:           sts.hit = (rdata.remaining == '0);
      default:             sts.hit = 1'b0;
    endcase
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    re    = cmd.rd || cmd.shr;
    raddr = cmd.shr ? idx_p1[IW-1:0] : idx[IW-1:0];
    waddr = idx[IW-1:0];
    wdata = rdata;
    if (cmd.scan_end && (req == REQ_REG) && !full) begin
      we    = 1'b1;
      waddr = count[IW-1:0];
      wdata = '{id: rid, remaining: rwait, period: rper, expected: '0, tick_set: 1'b0};
    end else if (cmd.chk && (req == REQ_ADV)) begin
      we              = 1'b1;
      wdata.remaining = adv_rem;
    end else if (cmd.rwr) begin
      we              = 1'b1;
      wdata.remaining = r_val;
      wdata.expected  = rnow + {32'd0, r_val};
      wdata.tick_set  = 1'b1;
    end else if (cmd.shw) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  mtte_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (diff),
    .divisor   (rdata.period),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Table control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      arm_start <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.scan_end) begin
        case (req)
          REQ_REG: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          REQ_ARM: begin
            if (count != '0) begin
              arm_start <= rnow;
            end
          end
          REQ_ADV:   cursor <= '0;
          REQ_FETCH: begin
            if (count != '0) begin
              cursor <= count;
            end
          end
          default: ;
        endcase
      end
      if (cmd.chk && (req == REQ_FETCH) && sts.hit) begin
        cursor <= idx;
      end
      if (cmd.sh_end) begin
        count <= count - CW'(1);
      end
    end
  end

  // Request working registers and results.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req     <= req_type;
      rid     <= timer_id;
      rwait   <= wait_ms;
      rper    <= period_ms;
      rnow    <= now_tick;
      idx     <= (req_type == REQ_FETCH) ? cursor : '0;
      diff    <= now_tick - arm_start;
      min_val <= '1;
      res_st  <= ST_OK;
      res_fid <= '0;
      res_rem <= '0;
      res_per <= '0;
    end
    if (cmd.scan_end) begin
      case (req)
        REQ_REG: begin
          if (full) begin
            res_st <= ST_FULL;
          end
        end
        REQ_ARM: begin
          if (count == '0) begin
            res_st <= ST_MISSING;
          end else begin
            res_rem <= min_val;
          end
        end
        REQ_ADV: begin
          if (count == '0) begin
            res_st <= ST_MISSING;
          end
        end
        REQ_FETCH:  res_st <= (count == '0) ? ST_MISSING : ST_NONE;
        REQ_LOOKUP: res_st <= ST_MISSING;
        default: ;
      endcase
    end
    if (cmd.chk) begin
      if (sts.hit) begin
        case (req)
          REQ_REG: res_st <= ST_EXISTS;
          REQ_LOOKUP: begin
            res_fid <= rdata.id;
            res_rem <= rdata.remaining;
            res_per <= rdata.period;
          end
          REQ_FETCH: begin
            res_fid <= rdata.id;
            res_per <= rdata.period;
            diff    <= rnow - rdata.expected;
          end
          default: ;
        endcase
      end else begin
        idx <= idx + CW'(1);
      end
      if ((req == REQ_ARM) && (rdata.remaining < min_val)) begin
        min_val <= rdata.remaining;
      end
    end
    if (cmd.rld) begin
      r_val <= rld_val;
    end
    if (cmd.div_fin) begin
      r_val <= 32'(rdata.period - div_rem);
    end
    if (cmd.shw) begin
      idx <= idx_p1;
    end
    if (cmd.emit) begin
      status       <= res_st;
      fired_id     <= res_fid;
      remaining_ms <= res_rem;
      entry_period <= res_per;
      live_count   <= count;
    end
  end

endmodule

FILE: rtl/core/mtte_ctrl.sv
module mtte_ctrl import mtte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_RLD  = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_RWR  = 9'b000100000,
    S_SHR  = 9'b001000000,
    S_SHW  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.scan_more) begin
          cmd.rd     = 1'b1;
          state_next = S_CHK;
        end else begin
          cmd.scan_end = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (!sts.hit) begin
          state_next = S_RD;
        end else if (!sts.is_fetch) begin
          state_next = S_DONE;
        end else if (sts.periodic) begin
          state_next = S_RLD;
        end else begin
          state_next = S_SHR;
        end
      end
      S_RLD: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.rld    = 1'b1;
          state_next = S_RWR;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_fin = 1'b1;
          state_next  = S_RWR;
        end
      end
      S_RWR: begin
        cmd.rwr    = 1'b1;
        state_next = S_DONE;
      end
      S_SHR: begin
        if (sts.sh_more) begin
          cmd.shr    = 1'b1;
          state_next = S_SHW;
        end else begin
          cmd.sh_end = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SHW: begin
        cmd.shw    = 1'b1;
        state_next = S_SHR;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/multi_timer_table_engine.sv
// Each request scans the live entries from the start (a fetch from its cursor) until a match
// or the end of the table. A one-shot fetch then moves each later entry up; a periodic fetch
// computes its reload, through the remainder unit when it is a period or more late.
// Throughput: one request at a time; the next request is taken once this one's result is
// registered, even while that result still waits to be taken.
// Reset (rst, synchronous, active high) empties the table, rewinds cursor and arm tick, and
// drops any pending result; table memory contents are not cleared.
module multi_timer_table_engine import mtte_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic [2:0]    req_type,
  input  logic [31:0]   timer_id,
  input  logic [31:0]   wait_ms,
  input  logic [31:0]   period_ms,
  input  logic [63:0]   now_tick,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic [2:0]    status,
  output logic [31:0]   fired_id,
  output logic [31:0]   remaining_ms,
  output logic [31:0]   entry_period,
  output logic [CW-1:0] live_count
);

  // The controller sequences each request as a walk over the live entries; the
  // datapath owns the entry memory, the scan index, the table counters and the
  // result registers. They talk only through the command and status structs.
  cmd_t cmd;
  sts_t sts;

  mtte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // A request transfer latches all fields; the result transfer happens from a
  // separate output register so a finished result never blocks the next scan.
  mtte_dp #(.SLOTS(SLOTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .timer_id     (timer_id),
    .wait_ms      (wait_ms),
    .period_ms    (period_ms),
    .now_tick     (now_tick),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .fired_id     (fired_id),
    .remaining_ms (remaining_ms),
    .entry_period (entry_period),
    .live_count   (live_count)
  );

endmodule

FILE: rtl/core/mtte_chk.sv
`include "assert_macros.svh"

module mtte_chk import mtte_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic [2:0]    req_type,
  input logic [31:0]   timer_id,
  input logic [31:0]   wait_ms,
  input logic [31:0]   period_ms,
  input logic [63:0]   now_tick,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input logic [2:0]    status,
  input logic [31:0]   fired_id,
  input logic [31:0]   remaining_ms,
  input logic [31:0]   entry_period,
  input logic [CW-1:0] live_count
);

  `ASSERT_ANY(a_rst_clears, clk, rst |=> !rsp_valid)
  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
  `ASSERT_CLK(a_count_max, clk, rst, rsp_valid |-> live_count <= CW'(SLOTS))
  `ASSERT_CLK(a_dup_quiet, clk, rst, rsp_valid && (status == ST_EXISTS) |-> (fired_id == '0) && (remaining_ms == '0) && (entry_period == '0))
  `ASSERT_CLK(a_busy_stall, clk, rst, req_valid && !req_stall |=> req_stall)

endmodule

bind multi_timer_table_engine mtte_chk #(.SLOTS(SLOTS)) u_chk (.*);

FILE: bench/tb.sv
module tb;
  import mtte_pkg::*;

  // Clock, reset and the handshake signals on both sides of the engine.
  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [2:0]  req_type;
  logic [31:0] timer_id;
  logic [31:0] wait_ms;
  logic [31:0] period_ms;
  logic [63:0] now_tick;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [2:0]  status;
  logic [31:0] fired_id;
  logic [31:0] remaining_ms;
  logic [31:0] entry_period;
  logic [4:0]  live_count;

  // One request as it is handed to the engine.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [31:0] wait_v;
    logic [31:0] period;
    logic [63:0] tick;
  } timer_req_t;

  // One result as the engine should report it.
  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] fid;
    logic [31:0] rem;
    logic [31:0] per;
    logic [4:0]  cnt;
  } timer_rsp_t;

  timer_req_t pending_reqs[$];
  timer_rsp_t expected_rsps[$];

  // The predictor keeps its own copy of the timer table.
  logic [31:0] tbl_id[16];
  logic [31:0] tbl_rem[16];
  logic [31:0] tbl_per[16];
  logic [63:0] tbl_exp[16];
  logic        tbl_tick_set[16];
  int          tbl_count;
  int          tbl_cursor;
  logic [63:0] tbl_arm_tick;

  int  error_count = 0;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  send_hold;
  // Set at each rising edge where a request transfer took place.
  bit  req_taken;

  // Used ids stay in a small pool so that duplicates and lookup hits are common.
  logic [31:0] id_pool[8];
  logic [63:0] tick_now;

  multi_timer_table_engine u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .timer_id(timer_id), .wait_ms(wait_ms),
    .period_ms(period_ms), .now_tick(now_tick),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .fired_id(fired_id), .remaining_ms(remaining_ms),
    .entry_period(entry_period), .live_count(live_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int find_timer(logic [31:0] id);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Reload value of a periodic timer, with drift correction against the tick at
  // which it was last due. A timer that has never fired reloads its plain period.
  function automatic logic [31:0] reload_time(int k, logic [63:0] tick);
    logic [63:0] per;
    logic [63:0] drift;
    logic [63:0] early;
    logic [63:0] sum;
    per = {32'd0, tbl_per[k]};
    if (!tbl_tick_set[k]) return tbl_per[k];
    drift = tick - tbl_exp[k];
    if (drift[63]) begin
      early = 64'd0 - drift;
      sum = per + early;
      if (early > 64'hFFFF_FFFF || sum > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return sum[31:0];
    end
    if (drift >= per) return 32'(per - (drift % per));
    return 32'(per - drift);
  endfunction

  // Applies one request to the table copy and returns the expected result.
  function automatic timer_rsp_t predict_timer_rsp(timer_req_t r);
    timer_rsp_t o;
    logic [63:0] elapsed;
    logic [31:0] m;
    logic [31:0] rl;
    int k;
    int i;
    o = '0;
    case (r.kind)
      REQ_REG: begin
        if (find_timer(r.id) >= 0) o.st = ST_EXISTS;
        else if (tbl_count >= 16) o.st = ST_FULL;
        else begin
          tbl_id[tbl_count] = r.id;
          tbl_rem[tbl_count] = r.wait_v;
          tbl_per[tbl_count] = r.period;
          tbl_exp[tbl_count] = '0;
          tbl_tick_set[tbl_count] = 1'b0;
          tbl_count++;
        end
      end
      REQ_ARM: begin
        if (tbl_count == 0) o.st = ST_MISSING;
        else begin
          m = tbl_rem[0];
          for (i = 1; i < tbl_count; i++) if (tbl_rem[i] < m) m = tbl_rem[i];
          tbl_arm_tick = r.tick;
          o.rem = m;
        end
      end
      REQ_ADV: begin
        elapsed = r.tick - tbl_arm_tick;
        for (i = 0; i < tbl_count; i++) begin
          if ({32'd0, tbl_rem[i]} <= elapsed) tbl_rem[i] = '0;
          else tbl_rem[i] = tbl_rem[i] - elapsed[31:0];
        end
        tbl_cursor = 0;
        if (tbl_count == 0) o.st = ST_MISSING;
      end
      REQ_FETCH: begin
        if (tbl_count == 0) o.st = ST_MISSING;
        else begin
          o.st = ST_NONE;
          for (i = tbl_cursor; i < tbl_count; i++) begin
            if (tbl_rem[i] == 0) break;
          end
          if (i < tbl_count) begin
            o.st = ST_OK;
            o.fid = tbl_id[i];
            o.per = tbl_per[i];
            if (tbl_per[i] != 0) begin
              rl = reload_time(i, r.tick);
              tbl_rem[i] = rl;
              tbl_exp[i] = r.tick + {32'd0, rl};
              tbl_tick_set[i] = 1'b1;
            end else begin
              // A one-shot leaves the table and later entries move up.
              for (k = i; k + 1 < tbl_count; k++) begin
                tbl_id[k] = tbl_id[k+1];
                tbl_rem[k] = tbl_rem[k+1];
                tbl_per[k] = tbl_per[k+1];
                tbl_exp[k] = tbl_exp[k+1];
                tbl_tick_set[k] = tbl_tick_set[k+1];
              end
              tbl_count--;
            end
          end
          tbl_cursor = i;
        end
      end
      REQ_LOOKUP: begin
        k = find_timer(r.id);
        if (k < 0) o.st = ST_MISSING;
        else begin
          o.fid = tbl_id[k];
          o.rem = tbl_rem[k];
          o.per = tbl_per[k];
        end
      end
      default: ;
    endcase
    o.cnt = 5'(tbl_count);
    return o;
  endfunction

  // Driver: presents the oldest pending request at the falling edge and holds it
  // until a transfer takes place. A transfer seen at the last rising edge is
  // predicted here, while its payload is still on the ports.
  always @(negedge clk) begin
    timer_req_t r;
    timer_rsp_t e;
    if (rst) begin
      req_valid <= 1'b0;
      req_type <= '0;
      timer_id <= '0;
      wait_ms <= '0;
      period_ms <= '0;
      now_tick <= '0;
      rsp_stall <= 1'b0;
    end else begin
      if (req_taken) begin
        e = predict_timer_rsp({req_type, timer_id, wait_ms, period_ms, now_tick});
        expected_rsps = {expected_rsps, e};
        void'(pending_reqs.pop_front());
      end
      if (req_valid && !req_taken) begin
        // A request that was not taken keeps its payload.
      end else if (pending_reqs.size() != 0 && !send_hold &&
                   $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs[0];
        req_valid <= 1'b1;
        req_type <= r.kind;
        timer_id <= r.id;
        wait_ms <= r.wait_v;
        period_ms <= r.period;
        now_tick <= r.tick;
      end else begin
        req_valid <= 1'b0;
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: notes request transfers and compares each transfer on the result
  // side with the oldest expectation.
  always @(posedge clk) begin
    timer_rsp_t e;
    req_taken = !rst && req_valid && !req_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        e = expected_rsps.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          error_count++;
        end
        if (fired_id !== e.fid) begin
          $error("fired_id: expected %h, got %h", e.fid, fired_id);
          error_count++;
        end
        if (remaining_ms !== e.rem) begin
          $error("remaining_ms: expected %h, got %h", e.rem, remaining_ms);
          error_count++;
        end
        if (entry_period !== e.per) begin
          $error("entry_period: expected %h, got %h", e.per, entry_period);
          error_count++;
        end
        if (live_count !== e.cnt) begin
          $error("live_count: expected %0d, got %0d", e.cnt, live_count);
          error_count++;
        end
      end
    end
  end

  task automatic add_req(logic [2:0] kind, logic [31:0] id, logic [31:0] wait_v,
                         logic [31:0] period, logic [63:0] tick);
    timer_req_t r;
    r = {kind, id, wait_v, period, tick};
    pending_reqs = {pending_reqs, r};
  endtask

  // Waits until every queued request has been taken and every result checked.
  task automatic drain_all();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
  endtask

  // Mostly small waits and periods so that timers expire often; now and then
  // the full 32-bit range. Ticks move forward mostly, sometimes backward or wide.
  task automatic add_random_req();
    logic [31:0] id;
    logic [31:0] w;
    logic [31:0] p;
    logic [2:0]  kind;
    int sel;
    sel = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)];
    if (id == 32'hFFFF_FFFF) id = 32'hFFFF_FFFE;
    w = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
    p = ($urandom_range(2) == 0) ? 32'd0 :
        ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 40);
    case ($urandom_range(19))
      0: tick_now = {$urandom, $urandom};
      1: tick_now = tick_now - 64'($urandom_range(80));
      default: tick_now = tick_now + 64'($urandom_range(30));
    endcase
    if (sel < 26) kind = REQ_REG;
    else if (sel < 40) kind = REQ_ARM;
    else if (sel < 56) kind = REQ_ADV;
    else if (sel < 86) kind = REQ_FETCH;
    else if (sel < 97) kind = REQ_LOOKUP;
    else kind = 3'($urandom_range(5, 7));
    add_req(kind, id, w, p, tick_now);
  endtask

  initial begin
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_hold = 1'b0;
    tick_now = 64'd1000;
    tbl_count = 0;
    tbl_cursor = 0;
    tbl_arm_tick = '0;
    for (int i = 0; i < 16; i++) begin
      tbl_id[i] = '0;
      tbl_rem[i] = '0;
      tbl_per[i] = '0;
      tbl_exp[i] = '0;
      tbl_tick_set[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'd0;
    id_pool[1] = 32'hFFFF_FFFE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty-table cases, extremes, duplicates, both timer kinds, an unknown kind and a full table.
    add_req(REQ_ARM, 0, 0, 0, 64'd5);
    add_req(REQ_FETCH, 0, 0, 0, 64'd5);
    add_req(REQ_ADV, 0, 0, 0, 64'd7);
    add_req(REQ_LOOKUP, 32'h1234, 0, 0, 64'd0);
    add_req(REQ_REG, 32'h0, 32'd0, 32'd0, 64'd0);
    add_req(REQ_REG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    add_req(REQ_REG, 32'h0, 32'd5, 32'd5, 64'd0);
    add_req(REQ_REG, 32'h55, 32'd10, 32'd7, 64'd0);
    add_req(REQ_LOOKUP, 32'hFFFF_FFFF, 0, 0, 64'd0);
    add_req(REQ_ARM, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
    add_req(REQ_FETCH, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
    add_req(REQ_FETCH, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
    add_req(REQ_ADV, 0, 0, 0, 64'd20);
    add_req(REQ_FETCH, 0, 0, 0, 64'd20);
    add_req(REQ_FETCH, 0, 0, 0, 64'd60);
    add_req(REQ_ADV, 0, 0, 0, 64'd40);
    add_req(REQ_FETCH, 0, 0, 0, 64'd2);
    add_req(REQ_FETCH, 0, 0, 0, 64'h8000_0000_0000_0000);
    add_req(3'd7, 32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF, '1);
    for (int i = 0; i < 16; i++) add_req(REQ_REG, 32'h100 + i, i, i % 3, 64'd0);
    add_req(REQ_LOOKUP, 32'h10F, 0, 0, 64'd0);
    drain_all();

    // Random phases with different idling mixes; the sender holds off once
    // until everything outstanding has come back.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 45 : (ph == 3) ? 19 : 0;
      recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 19 : 0;
      for (int n = 0; n < 135; n++) begin
        add_random_req();
        if (ph == 1 && n == 60) begin
          send_hold = 1'b1;
          while (expected_rsps.size() != 0 || req_valid) @(posedge clk);
          send_hold = 1'b0;
        end
      end
      drain_all();
    end
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mtte_pkg.sv
rtl/core/mtte_mod.sv
rtl/core/mtte_dp.sv
rtl/core/mtte_ctrl.sv
rtl/core/multi_timer_table_engine.sv
rtl/core/mtte_chk.sv
bench/tb.sv
